// File: sv/pfgr_pkg.sv
package pfgr_pkg;

	// Coordinates grow past 12 bits inside a glyph: x + col*scale, y + row*scale.
	localparam int COORD_W    = 14;
	// Frame byte address x + width*page, wide enough for any panel geometry.
	localparam int PIX_ADDR_W = 13;
	// Font pointer: (code-first)*cols*parts + start, plus the walk over the glyph.
	localparam int FONT_PTR_W = 24;

	localparam logic [FONT_PTR_W-1:0] GLYPH_DATA_START = 24'd5;
	localparam logic [FONT_PTR_W-1:0] FONT_HEIGHT_IDX  = 24'd0;
	localparam logic [FONT_PTR_W-1:0] FONT_COLS_IDX    = 24'd1;
	localparam logic [FONT_PTR_W-1:0] FONT_FIRST_IDX   = 24'd3;
	localparam logic [FONT_PTR_W-1:0] FONT_LAST_IDX    = 24'd4;

	localparam logic [2:0] MODE_CLEAR   = 3'd0;
	localparam logic [2:0] MODE_PIXEL   = 3'd1;
	localparam logic [2:0] MODE_RECT    = 3'd2;
	localparam logic [2:0] MODE_GLYPH   = 3'd3;
	localparam logic [2:0] MODE_READ    = 3'd4;
	localparam logic [2:0] MODE_FONT_WR = 3'd5;

	localparam logic CFG_PANEL_WIDTH  = 1'b0;
	localparam logic CFG_PANEL_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		OP_CLEAR   = 3'd0,
		OP_BOX     = 3'd1,
		OP_GLYPH   = 3'd2,
		OP_READ    = 3'd3,
		OP_FONT_WR = 3'd4,
		OP_NOP     = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  box_w;
		logic [7:0]  box_h;
		logic [3:0]  scale;
		logic [7:0]  code;
		logic [9:0]  index;
		logic [7:0]  data;
	} cmd_t;

endpackage

// File: sv/pfgr_if.sv
interface pfgr_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [7:0]  rect_width;
	logic [7:0]  rect_height;
	logic [3:0]  glyph_scale;
	logic [7:0]  char_code;
	logic [9:0]  table_index;
	logic [7:0]  table_data;

	modport source (output valid, mode, pos_x, pos_y, rect_width, rect_height,
		glyph_scale, char_code, table_index, table_data, input ready);
	modport sink (input valid, mode, pos_x, pos_y, rect_width, rect_height,
		glyph_scale, char_code, table_index, table_data, output ready);
endinterface

interface pfgr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       status;

	modport source (output valid, read_data, status, input ready);
	modport sink (input valid, read_data, status, output ready);
endinterface

// File: sv/pfgr_front.sv
module pfgr_front
	import pfgr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	pfgr_in_if.sink in_ch,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_pop
);

	cmd_t       cls;
	cmd_t       fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	// A single pixel is a one by one box, so the back end draws pixels and rectangles alike.
	always_comb begin
		cls.op    = OP_NOP;
		cls.pos_x = in_ch.pos_x;
		cls.pos_y = in_ch.pos_y;
		cls.box_w = in_ch.rect_width;
		cls.box_h = in_ch.rect_height;
		cls.scale = in_ch.glyph_scale;
		cls.code  = in_ch.char_code;
		cls.index = in_ch.table_index;
		cls.data  = in_ch.table_data;
		unique case (in_ch.mode)
			MODE_CLEAR:   cls.op = OP_CLEAR;
			MODE_PIXEL: begin
				cls.op    = OP_BOX;
				cls.box_w = 8'd1;
				cls.box_h = 8'd1;
			end
			MODE_RECT:    cls.op = OP_BOX;
			MODE_GLYPH:   cls.op = OP_GLYPH;
			MODE_READ:    cls.op = OP_READ;
			MODE_FONT_WR: cls.op = OP_FONT_WR;
			default:      cls.op = OP_NOP;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (cnt_q != 2'd0);
	assign pop         = cmd_pop && cmd_valid;
	assign cmd         = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/pfgr_back.sv
module pfgr_back
	import pfgr_pkg::*;
#(
	parameter int FRAME_BYTES = 1024,
	parameter int FONT_BYTES  = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic [7:0] panel_width,
	input  logic [6:0] panel_height,
	pfgr_out_if.source out_ch
);

	localparam int FA_W = $clog2(FRAME_BYTES);
	localparam int FN_W = $clog2(FONT_BYTES);

	typedef enum logic [14:0] {
		ST_INIT      = 15'b000000000000001,
		ST_IDLE      = 15'b000000000000010,
		ST_DISP      = 15'b000000000000100,
		ST_CLEAR     = 15'b000000000001000,
		ST_READ      = 15'b000000000010000,
		ST_HDR       = 15'b000000000100000,
		ST_CHK       = 15'b000000001000000,
		ST_MUL       = 15'b000000010000000,
		ST_FONT_RD   = 15'b000000100000000,
		ST_FONT_WAIT = 15'b000001000000000,
		ST_BIT       = 15'b000010000000000,
		ST_BOX_SET   = 15'b000100000000000,
		ST_BOX_RD    = 15'b001000000000000,
		ST_BOX_WR    = 15'b010000000000000,
		ST_DONE      = 15'b100000000000000
	} state_t;

	logic [7:0] frame_mem [FRAME_BYTES];
	logic [7:0] font_mem [FONT_BYTES];

	state_t state_q, state_d, ret_q, glyph_nxt;
	cmd_t   cmd_q;

	logic [FA_W-1:0]       clr_q;
	logic [2:0]            hc_q;
	logic [7:0]            f_height_q, f_cols_q, f_first_q, f_last_q;
	logic [5:0]            parts_q;
	logic [15:0]           prod_q;
	logic [FONT_PTR_W-1:0] ptr_q;
	logic [7:0]            col_q;
	logic [5:0]            part_q;
	logic [2:0]            bit_q;
	logic [7:0]            bits_q;
	logic [COORD_W-1:0]    gx_q, gpy_q, by_q;
	logic [COORD_W-1:0]    box_x_q, box_y_q;
	logic [7:0]            box_w_q, box_h_q;
	logic [7:0]            cx_q, xe_q;
	logic [3:0]            pg_q;
	logic [6:0]            y0_q, ye_q;
	logic [PIX_ADDR_W-1:0] waddr_q;
	logic [7:0]            mask_q;
	logic                  wen_ok_q;
	logic [7:0]            fr_rd_q, fn_rd_q;
	logic                  fn_oob_q;
	logic                  rd_ok_q;
	logic [7:0]            res_data_q;
	logic                  res_status_q;
	logic                  ov_q;
	logic [7:0]            out_data_q;
	logic                  out_status_q;

	logic [PIX_ADDR_W-1:0] fr_raddr, box_addr;
	logic [11:0]           pg_off;
	logic                  box_ok;
	logic [7:0]            mask;
	logic [6:0]            yy;
	logic [FONT_PTR_W-1:0] f_raddr, cmd_idx_ext;
	logic [7:0]            font_val;
	logic [7:0]            code_diff;
	logic [15:0]           mul1;
	logic [21:0]           mul2;
	logic [14:0]           xs, ys, xe_full, ye_full;
	logic                  box_live;
	logic [3:0]            pg_last;
	logic                  fr_we, font_we, out_load;
	logic [FA_W-1:0]       fr_waddr;
	logic [7:0]            fr_wdata;
	logic [COORD_W-1:0]    scale_ext, scale_x8, pos_x_ext, pos_y_ext;
	logic                  last_bit, last_part, last_col, cls_last;

	assign cmd_idx_ext = {14'd0, cmd_q.index};
	assign scale_ext   = {10'd0, cmd_q.scale};
	assign scale_x8    = {7'd0, cmd_q.scale, 3'd0};
	assign pos_x_ext   = {2'd0, cmd_q.pos_x};
	assign pos_y_ext   = {2'd0, cmd_q.pos_y};
	assign font_val    = fn_oob_q ? 8'd0 : fn_rd_q;
	assign code_diff   = cmd_q.code - f_first_q;
	assign mul1        = code_diff * f_cols_q;
	assign mul2        = prod_q * parts_q;
	assign out_load    = (state_q == ST_DONE) && (!ov_q || out_ch.ready);
	assign cmd_pop     = (state_q == ST_IDLE) && cmd_valid;

	// Byte address and bit mask of the current column inside the current page.
	assign pg_off   = panel_width * pg_q;
	assign box_addr = {5'd0, cx_q} + {1'b0, pg_off};
	assign box_ok   = box_addr < PIX_ADDR_W'(FRAME_BYTES);
	assign pg_last  = 4'((ye_q - 7'd1) >> 3);

	always_comb begin
		mask = 8'd0;
		yy   = 7'd0;
		for (int b = 0; b < 8; b++) begin
			yy      = {pg_q, 3'(b)};
			mask[b] = (yy >= y0_q) && (yy < ye_q);
		end
	end

	// Clip a box against the panel.
	assign xs       = {1'b0, box_x_q} + {7'd0, box_w_q};
	assign ys       = {1'b0, box_y_q} + {7'd0, box_h_q};
	assign xe_full  = (xs < {7'd0, panel_width}) ? xs : {7'd0, panel_width};
	assign ye_full  = (ys < {8'd0, panel_height}) ? ys : {8'd0, panel_height};
	assign box_live = ({1'b0, box_x_q} < xe_full) && ({1'b0, box_y_q} < ye_full);

	// Glyph walk: bits of a font byte, then parts of a column, then columns.
	assign last_bit  = (bit_q == 3'd7);
	assign last_part = (part_q == parts_q - 6'd1);
	assign last_col  = (col_q == f_cols_q - 8'd1);
	assign cls_last  = (clr_q == FA_W'(FRAME_BYTES - 1));

	always_comb begin
		if (!last_bit) begin
			glyph_nxt = ST_BIT;
		end else if (!last_part || !last_col) begin
			glyph_nxt = ST_FONT_RD;
		end else begin
			glyph_nxt = ST_DONE;
		end
	end

	always_comb begin
		fr_raddr = (state_q == ST_BOX_RD) ? box_addr : {3'd0, cmd_q.index};
		unique case (hc_q)
			3'd0:    f_raddr = FONT_HEIGHT_IDX;
			3'd1:    f_raddr = FONT_COLS_IDX;
			3'd2:    f_raddr = FONT_FIRST_IDX;
			3'd3:    f_raddr = FONT_LAST_IDX;
			default: f_raddr = FONT_HEIGHT_IDX;
		endcase
		if (state_q == ST_FONT_RD) begin
			f_raddr = ptr_q;
		end
	end

	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = clr_q;
		fr_wdata = 8'd0;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			fr_we = 1'b1;
		end else if (state_q == ST_BOX_WR && wen_ok_q) begin
			fr_we    = 1'b1;
			fr_waddr = waddr_q[FA_W-1:0];
			fr_wdata = fr_rd_q | mask_q;
		end
	end

	assign font_we = (state_q == ST_DISP) && (cmd_q.op == OP_FONT_WR) &&
		(cmd_idx_ext < FONT_PTR_W'(FONT_BYTES));

	always_ff @(posedge clk) begin
		fr_rd_q <= frame_mem[fr_raddr[FA_W-1:0]];
		if (fr_we) begin
			frame_mem[fr_waddr] <= fr_wdata;
		end
	end

	always_ff @(posedge clk) begin
		fn_rd_q  <= font_mem[f_raddr[FN_W-1:0]];
		fn_oob_q <= f_raddr >= FONT_PTR_W'(FONT_BYTES);
		if (font_we) begin
			font_mem[cmd_idx_ext[FN_W-1:0]] <= cmd_q.data;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:      state_d = cls_last ? ST_IDLE : ST_INIT;
			ST_IDLE:      state_d = cmd_valid ? ST_DISP : ST_IDLE;
			ST_DISP: begin
				unique case (cmd_q.op)
					OP_CLEAR: state_d = ST_CLEAR;
					OP_BOX:   state_d = ST_BOX_SET;
					OP_GLYPH: state_d = ST_HDR;
					OP_READ:  state_d = ST_READ;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_CLEAR:     state_d = cls_last ? ST_DONE : ST_CLEAR;
			ST_READ:      state_d = ST_DONE;
			ST_HDR:       state_d = (hc_q == 3'd4) ? ST_CHK : ST_HDR;
			ST_CHK: begin
				if (cmd_q.code < f_first_q || cmd_q.code > f_last_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cmd_q.scale == 4'd0 || f_cols_q == 8'd0 || parts_q == 6'd0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FONT_RD;
				end
			end
			ST_FONT_RD:   state_d = ST_FONT_WAIT;
			ST_FONT_WAIT: state_d = ST_BIT;
			ST_BIT:       state_d = bits_q[bit_q] ? ST_BOX_SET : glyph_nxt;
			ST_BOX_SET:   state_d = box_live ? ST_BOX_RD : ret_q;
			ST_BOX_RD:    state_d = ST_BOX_WR;
			ST_BOX_WR: begin
				if (pg_q == pg_last && cx_q == xe_q - 8'd1) begin
					state_d = ret_q;
				end else begin
					state_d = ST_BOX_RD;
				end
			end
			ST_DONE:      state_d = out_load ? ST_IDLE : ST_DONE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ret_q   <= ST_DONE;
			clr_q   <= '0;
			hc_q    <= 3'd0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				clr_q <= clr_q + FA_W'(1);
			end else if (state_q == ST_DISP) begin
				clr_q <= '0;
			end
			if (state_q == ST_HDR) begin
				hc_q <= hc_q + 3'd1;
			end else if (state_q == ST_DISP) begin
				hc_q <= 3'd0;
			end
			if (state_q == ST_DISP) begin
				ret_q <= ST_DONE;
			end else if (state_q == ST_BIT) begin
				ret_q <= glyph_nxt;
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (out_load) begin
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
		end
		unique case (state_q)
			ST_DISP: begin
				res_data_q   <= 8'd0;
				res_status_q <= 1'b0;
				rd_ok_q      <= {3'd0, cmd_q.index} < PIX_ADDR_W'(FRAME_BYTES);
				box_x_q      <= pos_x_ext;
				box_y_q      <= pos_y_ext;
				box_w_q      <= cmd_q.box_w;
				box_h_q      <= cmd_q.box_h;
			end
			ST_READ: begin
				res_data_q <= rd_ok_q ? fr_rd_q : 8'd0;
			end
			ST_HDR: begin
				unique case (hc_q)
					3'd1:    f_height_q <= font_val;
					3'd2:    f_cols_q   <= font_val;
					3'd3:    f_first_q  <= font_val;
					3'd4:    f_last_q   <= font_val;
					default: ;
				endcase
			end
			ST_CHK: begin
				if (cmd_q.code < f_first_q || cmd_q.code > f_last_q) begin
					res_status_q <= 1'b1;
				end
				parts_q <= {1'b0, f_height_q[7:3]} + {5'd0, (f_height_q[2:0] != 3'd0)};
				prod_q  <= mul1;
			end
			ST_MUL: begin
				ptr_q  <= {2'd0, mul2} + GLYPH_DATA_START;
				col_q  <= 8'd0;
				part_q <= 6'd0;
				gx_q   <= pos_x_ext;
				gpy_q  <= pos_y_ext;
			end
			ST_FONT_WAIT: begin
				bits_q <= font_val;
				bit_q  <= 3'd0;
				by_q   <= gpy_q;
			end
			ST_BIT: begin
				box_x_q <= gx_q;
				box_y_q <= by_q;
				box_w_q <= {4'd0, cmd_q.scale};
				box_h_q <= {4'd0, cmd_q.scale};
				bit_q   <= bit_q + 3'd1;
				by_q    <= by_q + scale_ext;
				if (last_bit) begin
					ptr_q <= ptr_q + FONT_PTR_W'(1);
					if (!last_part) begin
						part_q <= part_q + 6'd1;
						gpy_q  <= gpy_q + scale_x8;
					end else begin
						part_q <= 6'd0;
						gpy_q  <= pos_y_ext;
						col_q  <= col_q + 8'd1;
						gx_q   <= gx_q + scale_ext;
					end
				end
			end
			ST_BOX_SET: begin
				cx_q <= box_x_q[7:0];
				xe_q <= xe_full[7:0];
				y0_q <= box_y_q[6:0];
				ye_q <= ye_full[6:0];
				pg_q <= box_y_q[6:3];
			end
			ST_BOX_RD: begin
				waddr_q  <= box_addr;
				mask_q   <= mask;
				wen_ok_q <= box_ok;
			end
			ST_BOX_WR: begin
				if (pg_q != pg_last) begin
					pg_q <= pg_q + 4'd1;
				end else begin
					pg_q <= y0_q[6:3];
					cx_q <= cx_q + 8'd1;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid     = ov_q;
	assign out_ch.read_data = out_data_q;
	assign out_ch.status    = out_status_q;

	a_box_col_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BOX_RD |-> cx_q < xe_q)
		else $error("box column beyond clipped right edge");

	a_box_page_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BOX_RD |-> {pg_q, 3'b000} < ye_q)
		else $error("box page beyond clipped bottom edge");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ov_q)
		else $error("finished request did not reach the output register");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == ST_IDLE) && cmd_valid)
		else $error("queue popped outside idle or while empty");

endmodule

// File: sv/page_framebuffer_glyph_rasterizer.sv
// Drawing engine for a one-bit, page-organized framebuffer (eight vertical pixels to a byte,
// byte x + panel_width*(y/8)). Each request on in_ch carries a mode: clear, set pixel, fill
// rectangle, draw a scaled glyph from the font table, read a frame byte, or write a font byte;
// each request gives exactly one response on out_ch, in order. Pixels outside the panel are
// clipped. A front end takes requests into a two-entry queue, and a back end executes them one
// at a time, so two queued requests, one finished request in the back end and one response in
// the output register can be held while the downstream stalls. Every drawn frame byte is a
// read-modify-write: it is read in ST_BOX_RD and written back in ST_BOX_WR. A glyph reads the
// font header, checks the code range and sets up, then reads each font byte in turn and draws
// a scale-by-scale box for every set dot. After reset the block sweeps the frame memory to zero
// before it takes requests from its queue; the user must write panel_width and panel_height
// through the cfg port only while the block is idle, and the block itself does not enforce it.
module page_framebuffer_glyph_rasterizer
	import pfgr_pkg::*;
#(
	parameter int FRAME_BYTES = 1024,
	parameter int FONT_BYTES  = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	pfgr_in_if.sink    in_ch,
	pfgr_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_wdata
);

	logic [7:0] panel_width_q;
	logic [6:0] panel_height_q;
	logic       cmd_valid;
	logic       cmd_pop;
	cmd_t       cmd;

	// Panel geometry registers: they clip drawn pixels, and the width sets the page stride.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= 8'd128;
			panel_height_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PANEL_WIDTH:  panel_width_q  <= cfg_wdata;
				CFG_PANEL_HEIGHT: panel_height_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// The front end decodes the mode and queues the request.
	pfgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// The back end owns both memories and produces the response.
	pfgr_back #(
		.FRAME_BYTES (FRAME_BYTES),
		.FONT_BYTES  (FONT_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.panel_width  (panel_width_q),
		.panel_height (panel_height_q),
		.out_ch       (out_ch)
	);

endmodule

// File: bench/page_framebuffer_glyph_rasterizer_test.sv
module page_framebuffer_glyph_rasterizer_test;
	import pfgr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_BYTES = 1024;
	localparam int FONT_BYTES  = 1024;

	// Modes six and seven have no name in the package. They must do nothing and answer zero.
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	// Font header byte that the block never reads.
	localparam int FONT_SPARE_IDX = 2;

	// Font bytes loaded up front. Sixteen codes of at most six columns of two bytes fit.
	localparam int FONT_LOADED = 200;

	localparam int RANDOM_REQUESTS = 180;
	localparam int HOLD_CYCLES     = 400;

	typedef struct {
		logic [2:0]  mode;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  rect_width;
		logic [7:0]  rect_height;
		logic [3:0]  glyph_scale;
		logic [7:0]  char_code;
		logic [9:0]  table_index;
		logic [7:0]  table_data;
	} draw_req_t;

	typedef struct {
		logic [7:0] read_data;
		logic       status;
	} draw_rsp_t;

	// One row of the directed table. When typed is set, the response is the one written in
	// the row; otherwise the predicted response is used.
	typedef struct {
		draw_req_t req;
		bit        typed;
		draw_rsp_t rsp;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [7:0] cfg_wdata;

	pfgr_in_if  in_ch ();
	pfgr_out_if out_ch ();

	page_framebuffer_glyph_rasterizer #(
		.FRAME_BYTES(FRAME_BYTES),
		.FONT_BYTES (FONT_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// The predictor keeps its own picture of the panel, the font and the panel geometry.
	logic [7:0] shadow_frame [FRAME_BYTES];
	logic [7:0] shadow_font [FONT_BYTES];
	int unsigned shadow_width;
	int unsigned shadow_height;

	// Responses still owed by the block, oldest first.
	draw_rsp_t pending_rsp [$];

	int fail_count;
	int accepted_count;
	int checked_count;
	int mode_count [8];
	int glyph_miss_count;
	bit quiet_idle;
	bit hold_done;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Set the bits of a clipped rectangle in the shadow frame.
	task automatic fill_shadow_box(input int unsigned x, input int unsigned y,
		input int unsigned w, input int unsigned h);
		int unsigned x_end;
		int unsigned y_end;
		int unsigned addr;
		x_end = x + w;
		y_end = y + h;
		if (x_end > shadow_width) x_end = shadow_width;
		if (y_end > shadow_height) y_end = shadow_height;
		for (int unsigned xi = x; xi < x_end; xi++) begin
			for (int unsigned yi = y; yi < y_end; yi++) begin
				addr = xi + shadow_width * (yi >> 3);
				if (addr < FRAME_BYTES) shadow_frame[addr][yi & 7] = 1'b1;
			end
		end
	endtask

	function automatic logic [7:0] font_byte(input int unsigned idx);
		return (idx < FONT_BYTES) ? shadow_font[idx] : 8'h00;
	endfunction

	// Apply one request to the shadow state and work out the response the block owes.
	task automatic predict_draw(input draw_req_t req, output draw_rsp_t rsp);
		int unsigned glyph_h;
		int unsigned cols;
		int unsigned first;
		int unsigned last;
		int unsigned parts;
		int unsigned base;
		int unsigned sc;
		logic [7:0] bits;
		rsp.read_data = 8'h00;
		rsp.status = 1'b0;
		case (req.mode)
			MODE_CLEAR: begin
				foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
			end
			MODE_PIXEL: fill_shadow_box(req.pos_x, req.pos_y, 1, 1);
			MODE_RECT: fill_shadow_box(req.pos_x, req.pos_y, req.rect_width, req.rect_height);
			MODE_GLYPH: begin
				glyph_h = font_byte(FONT_HEIGHT_IDX);
				cols = font_byte(FONT_COLS_IDX);
				first = font_byte(FONT_FIRST_IDX);
				last = font_byte(FONT_LAST_IDX);
				sc = req.glyph_scale;
				if (req.char_code < first || req.char_code > last) begin
					rsp.status = 1'b1;
				end else begin
					// Each column takes as many bytes as the glyph height needs, bit 0 of the first byte at the top.
					parts = (glyph_h >> 3) + ((glyph_h & 7) != 0);
					base = (req.char_code - first) * cols * parts + GLYPH_DATA_START;
					for (int unsigned col = 0; col < cols; col++) begin
						for (int unsigned part = 0; part < parts; part++) begin
							bits = font_byte(base + col * parts + part);
							for (int unsigned b = 0; b < 8; b++) begin
								if (bits[b])
									fill_shadow_box(req.pos_x + col * sc,
										req.pos_y + ((part << 3) + b) * sc, sc, sc);
							end
						end
					end
				end
			end
			MODE_READ: rsp.read_data = shadow_frame[req.table_index];
			MODE_FONT_WR: shadow_font[req.table_index] = req.table_data;
			default: ;
		endcase
	endtask

	// Offer one request. Inputs change only at the falling edge; the request is taken at the
	// first rising edge where ready is high, and the expectation is queued right there.
	task automatic send_draw(input draw_req_t req, input bit typed, input draw_rsp_t typed_rsp);
		draw_rsp_t rsp;
		@(negedge clk);
		while (!quiet_idle && $urandom_range(99) < 24) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= req.mode;
		in_ch.pos_x <= req.pos_x;
		in_ch.pos_y <= req.pos_y;
		in_ch.rect_width <= req.rect_width;
		in_ch.rect_height <= req.rect_height;
		in_ch.glyph_scale <= req.glyph_scale;
		in_ch.char_code <= req.char_code;
		in_ch.table_index <= req.table_index;
		in_ch.table_data <= req.table_data;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_draw(req, rsp);
		pending_rsp.push_back(typed ? typed_rsp : rsp);
		accepted_count++;
		mode_count[req.mode]++;
		if (req.mode == MODE_GLYPH && rsp.status) glyph_miss_count++;
	endtask

	// Stop offering, wait for every owed response, then let the back end settle before the
	// geometry is changed underneath it.
	task automatic write_geometry(input int unsigned width, input int unsigned height);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_PANEL_WIDTH;
		cfg_wdata <= width[7:0];
		@(negedge clk);
		cfg_idx <= CFG_PANEL_HEIGHT;
		cfg_wdata <= height[7:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_width = width & 8'hFF;
		shadow_height = height & 8'h7F;
	endtask

	// Random request. Fields a mode does not use still carry random values. Coordinates mostly
	// land near the panel so that drawing is visible; now and then they span the full field.
	function automatic draw_req_t random_draw();
		draw_req_t req;
		int unsigned pick;
		int unsigned first;
		int unsigned last;
		req.pos_x = $urandom_range(99) < 85 ? 12'($urandom_range(shadow_width + 8))
			: 12'($urandom);
		req.pos_y = $urandom_range(99) < 85 ? 12'($urandom_range(shadow_height + 8))
			: 12'($urandom);
		req.rect_width = $urandom_range(99) < 90 ? 8'($urandom_range(20)) : 8'($urandom);
		req.rect_height = $urandom_range(99) < 90 ? 8'($urandom_range(20)) : 8'($urandom);
		req.glyph_scale = $urandom_range(99) < 80 ? 4'($urandom_range(3)) : 4'($urandom);
		first = shadow_font[FONT_FIRST_IDX];
		last = shadow_font[FONT_LAST_IDX];
		req.char_code = ($urandom_range(99) < 80 && first <= last) ?
			8'($urandom_range(last, first)) : 8'($urandom);
		req.table_index = 10'($urandom);
		req.table_data = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 20) req.mode = MODE_PIXEL;
		else if (pick < 35) req.mode = MODE_RECT;
		else if (pick < 57) req.mode = MODE_GLYPH;
		else if (pick < 82) req.mode = MODE_READ;
		else if (pick < 94) req.mode = MODE_FONT_WR;
		else if (pick < 96) req.mode = MODE_CLEAR;
		else req.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
		// Font writes leave the code range alone, and header rewrites keep the glyph small,
		// so that every glyph reads only bytes of the loaded part of the font.
		if (req.mode == MODE_FONT_WR) begin
			if ($urandom_range(99) < 15)
				req.table_index = 10'($urandom_range(2));
			else if (req.table_index < GLYPH_DATA_START[9:0])
				req.table_index = GLYPH_DATA_START[9:0];
			case (req.table_index)
				FONT_HEIGHT_IDX[9:0]: req.table_data = 8'($urandom_range(16, 1));
				FONT_COLS_IDX[9:0]: req.table_data = 8'($urandom_range(6, 1));
				default: ;
			endcase
		end
		return req;
	endfunction

	// Response side: ready idles at random, and once, well into the random part, it is held
	// low for a long stretch so that the queue fills and in_ch backs up.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_count >= FONT_LOADED + 120) begin
			out_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ch.ready <= quiet_idle || $urandom_range(99) >= 24;
		end
	end

	// Each response taken is checked field by field against the oldest expectation.
	always @(posedge clk) begin
		draw_rsp_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response with none outstanding: read_data %0h status %0b",
					out_ch.read_data, out_ch.status);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				checked_count++;
				if (out_ch.read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data, out_ch.read_data);
					fail_count++;
				end
				if (out_ch.status !== want.status) begin
					$error("status: expected %0b, got %0b", want.status, out_ch.status);
					fail_count++;
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#200ms;
		$display("page_framebuffer_glyph_rasterizer: mismatch");
		$finish;
	end

	initial begin
		directed_row_t rows [$];
		draw_req_t req;
		draw_req_t base_req;
		draw_rsp_t rsp0;
		draw_rsp_t no_rsp;
		int unsigned geom_w [6];
		int unsigned geom_h [6];

		fail_count = 0;
		accepted_count = 0;
		checked_count = 0;
		glyph_miss_count = 0;
		foreach (mode_count[i]) mode_count[i] = 0;
		quiet_idle = 1'b0;
		foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
		foreach (shadow_font[i]) shadow_font[i] = 8'h00;
		shadow_width = 128;
		shadow_height = 64;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_PANEL_WIDTH;
		cfg_wdata = 8'h00;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_CLEAR;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.rect_width = '0;
		in_ch.rect_height = '0;
		in_ch.glyph_scale = '0;
		in_ch.char_code = '0;
		in_ch.table_index = '0;
		in_ch.table_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		base_req = '{MODE_CLEAR, 12'd0, 12'd0, 8'd0, 8'd0, 4'd0, 8'd0, 10'd0, 8'd0};
		rsp0 = '{8'h00, 1'b0};
		no_rsp = rsp0;

		// Load the part of the font that glyphs can reach first, so that no glyph ever reads
		// an unwritten byte. The header gives an 8-high, 5-column font for codes 32 through 47.
		for (int i = 0; i < FONT_LOADED; i++) begin
			req = base_req;
			req.mode = MODE_FONT_WR;
			req.table_index = 10'(i);
			case (i)
				0: req.table_data = 8'd8;
				1: req.table_data = 8'd5;
				3: req.table_data = 8'd32;
				4: req.table_data = 8'd47;
				default: req.table_data = 8'($urandom);
			endcase
			send_draw(req, 1'b1, rsp0);
		end

		// Directed part: corners, clipping, empty shapes, the font range edges, scale zero and
		// the largest scale, and the unused modes.
		req = base_req; rows.push_back('{req, 1'b1, rsp0});
		req.mode = MODE_READ; req.table_index = 10'd0; rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_PIXEL; rows.push_back('{req, 1'b1, rsp0});
		req.mode = MODE_READ; rows.push_back('{req, 1'b1, '{8'h01, 1'b0}});
		req = base_req; req.mode = MODE_PIXEL; req.pos_x = 12'd127; req.pos_y = 12'd63;
		rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_READ; req.table_index = 10'd1023;
		rows.push_back('{req, 1'b1, '{8'h80, 1'b0}});
		req = base_req; req.mode = MODE_PIXEL; req.pos_x = 12'hFFF; req.pos_y = 12'hFFF;
		rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_RECT; req.pos_x = 12'd10; req.rect_height = 8'd20;
		rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_RECT; req.rect_width = 8'hFF; req.rect_height = 8'hFF;
		rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_READ; req.table_index = 10'd500;
		rows.push_back('{req, 1'b1, '{8'hFF, 1'b0}});
		req = base_req; rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_READ; req.table_index = 10'd500;
		rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_GLYPH; req.glyph_scale = 4'd1; req.char_code = 8'd0;
		rows.push_back('{req, 1'b1, '{8'h00, 1'b1}});
		req.char_code = 8'd31; rows.push_back('{req, 1'b1, '{8'h00, 1'b1}});
		req.char_code = 8'hFF; rows.push_back('{req, 1'b1, '{8'h00, 1'b1}});
		req.char_code = 8'd32; rows.push_back('{req, 1'b0, no_rsp});
		req.char_code = 8'd47; req.pos_x = 12'd100; rows.push_back('{req, 1'b0, no_rsp});
		req.glyph_scale = 4'd0; req.char_code = 8'd40; rows.push_back('{req, 1'b1, rsp0});
		req.glyph_scale = 4'hF; req.pos_x = 12'd40; req.pos_y = 12'd8;
		rows.push_back('{req, 1'b0, no_rsp});
		req = base_req; req.mode = MODE_READ; req.table_index = 10'd300;
		rows.push_back('{req, 1'b0, no_rsp});
		req = '{MODE_SPARE_6, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 4'hF, 8'hFF, 10'h3FF, 8'hFF};
		rows.push_back('{req, 1'b1, rsp0});
		req.mode = MODE_SPARE_7; rows.push_back('{req, 1'b1, rsp0});
		req = base_req; req.mode = MODE_FONT_WR; req.table_index = 10'(FONT_SPARE_IDX);
		req.table_data = 8'hFF; rows.push_back('{req, 1'b1, rsp0});
		foreach (rows[i]) send_draw(rows[i].req, rows[i].typed, rows[i].rsp);

		// Random part over several panel geometries, the extremes among them.
		geom_w = '{128, 1, 77, 128, 1, 100};
		geom_h = '{64, 8, 24, 8, 64, 40};
		for (int g = 0; g < 6; g++) begin
			write_geometry(geom_w[g], geom_h[g]);
			for (int n = 0; n < RANDOM_REQUESTS / 6 + 1; n++) begin
				// One long stretch without random idling on either side.
				quiet_idle = (g == 3);
				send_draw(random_draw(), 1'b0, no_rsp);
			end
			quiet_idle = 1'b0;
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Covered %0d requests (%0d clear, %0d pixel, %0d rect, %0d glyph, %0d read,",
			accepted_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
			mode_count[4]);
		$display("  %0d font write, %0d spare); %0d glyphs out of range, %0d responses checked.",
			mode_count[5], mode_count[6] + mode_count[7], glyph_miss_count, checked_count);
		if (fail_count == 0)
			$display("page_framebuffer_glyph_rasterizer: match");
		else
			$display("page_framebuffer_glyph_rasterizer: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
sv/pfgr_pkg.sv
sv/pfgr_if.sv
sv/pfgr_front.sv
sv/pfgr_back.sv
sv/page_framebuffer_glyph_rasterizer.sv
bench/page_framebuffer_glyph_rasterizer_test.sv
